### rtl/load_band_hold_monitor_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the load band hold monitor
// Short forms for clocked implication checks with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef LOAD_BAND_HOLD_MONITOR_CORE_ASSERT_SVH
`define LOAD_BAND_HOLD_MONITOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBHM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbhm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LBHM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbhm assertion failed");

`endif

### rtl/lbhm_pkg.sv
// ---------------------------------------------------------------------------
// lbhm_pkg
// Shared types, register codes, reset values and helpers of the monitor.
// ---------------------------------------------------------------------------
package lbhm_pkg;

  localparam int WEIGHT_W = 18;
  localparam int LIMIT_W  = 17;
  localparam int GAIN_W   = 24;
  localparam int RAW_W    = 24;
  localparam int HOLD_W   = 6;
  localparam int CNT_W    = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int SUM_W    = 26;

  typedef enum logic [2:0] {
    PH_INIT = 3'd0,
    PH_IDLE = 3'd1,
    PH_OUT  = 3'd2,
    PH_IN   = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOWER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_UPPER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SECONDS = 3'd5;

  // Register values after reset.
  localparam logic [GAIN_W-1:0]          GAIN_RST   = 24'd199582;
  localparam logic signed [WEIGHT_W-1:0] OFFSET_RST = 18'sd302;
  localparam logic [LIMIT_W-1:0]         LOWER_RST  = 17'd11520;
  localparam logic [LIMIT_W-1:0]         UPPER_RST  = 17'd16640;
  localparam logic [LIMIT_W-1:0]         EMPTY_RST  = 17'd768;
  localparam logic [HOLD_W-1:0]          HOLD_RST   = 6'd15;

  localparam logic signed [WEIGHT_W-1:0] W_MAX = 18'sd131071;
  localparam logic signed [WEIGHT_W-1:0] W_MIN = -18'sd131072;

  // Clamp a wide signed value into the 18-bit weight range.
  function automatic logic signed [WEIGHT_W-1:0] sat_weight(
      input logic signed [SUM_W-1:0] v);
    logic signed [WEIGHT_W-1:0] r;
    if (v > SUM_W'(W_MAX)) begin
      r = W_MAX;
    end else if (v < SUM_W'(W_MIN)) begin
      r = W_MIN;
    end else begin
      r = v[WEIGHT_W-1:0];
    end
    return r;
  endfunction

  // Signed weight is at least an unsigned limit.
  function automatic logic at_least(input logic signed [WEIGHT_W-1:0] w,
                                    input logic [LIMIT_W-1:0] lim);
    return !w[WEIGHT_W-1] && (w[LIMIT_W-1:0] >= lim);
  endfunction

endpackage

### rtl/load_band_hold_monitor_core.sv
// ---------------------------------------------------------------------------
// load_band_hold_monitor_core
// Scales load-cell samples, tares at most once, and tracks a weight hold in a band.
// ---------------------------------------------------------------------------
// Usage: each input word carries one raw converter sample and a flag telling
// that one second has passed since the previous word. Every input word
// produces exactly one result word with the tared weight, the phase reached,
// the band flag, the remaining hold seconds and the countdown display flag.
// Both data channels use valid and stall; a word moves at a clock edge with
// valid high and stall low. Configuration registers are written through a
// separate valid/ready port that is always ready; the user must write them
// only while no word is in flight, since the block has no check for it.
// A word is captured in the input register, and its result is then loaded
// into the output register. One word per cycle is sustained while the
// receiver does not stall; the multiply, the saturations and the phase
// update all sit between those two registers.
// When the receiver stalls, the result holds in the output register and one
// more word may wait in the input register; only then is in_stall raised.
// Synchronous reset empties both registers, returns the phase to init, clears
// the tare and the countdown, arms the first-sample tare and restores every
// configuration register to its default.
// ---------------------------------------------------------------------------
module load_band_hold_monitor_core (
  input  logic clk,
  input  logic rst,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [lbhm_pkg::RAW_W-1:0]    raw_reading,
  input  logic                                 second_tick,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lbhm_pkg::WEIGHT_W-1:0] net_weight,
  output logic [2:0]                           phase,
  output logic                                 in_band,
  output logic [lbhm_pkg::HOLD_W-1:0]          seconds_left,
  output logic                                 countdown_shown,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lbhm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lbhm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers.
  logic [lbhm_pkg::GAIN_W-1:0]          scale_gain;
  logic signed [lbhm_pkg::WEIGHT_W-1:0] scale_offset;
  logic [lbhm_pkg::LIMIT_W-1:0]         band_lower;
  logic [lbhm_pkg::LIMIT_W-1:0]         band_upper;
  logic [lbhm_pkg::LIMIT_W-1:0]         empty_limit;
  logic [lbhm_pkg::HOLD_W-1:0]          hold_seconds;

  // Input register.
  logic                              in_full;
  logic signed [lbhm_pkg::RAW_W-1:0] in_raw;
  logic                              in_tick;

  // Monitor state.
  lbhm_pkg::phase_t                     phase_reg;
  lbhm_pkg::phase_t                     phase_next;
  logic signed [lbhm_pkg::WEIGHT_W-1:0] tare_value;
  logic signed [lbhm_pkg::WEIGHT_W-1:0] tare_next;
  logic                                 first_sample;
  logic signed [lbhm_pkg::CNT_W-1:0]    countdown;
  logic signed [lbhm_pkg::CNT_W-1:0]    countdown_next;
  logic                                 countdown_visible;
  logic                                 countdown_visible_next;

  // Datapath.
  logic                                 accept;
  logic                                 advance;
  logic signed [lbhm_pkg::WEIGHT_W-1:0] scaled;
  logic signed [lbhm_pkg::WEIGHT_W-1:0] weight;
  logic                                 band;
  logic                                 loaded;
  logic [lbhm_pkg::HOLD_W-1:0]          seconds_next;

  // The configuration port never holds off a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_gain   <= lbhm_pkg::GAIN_RST;
      scale_offset <= lbhm_pkg::OFFSET_RST;
      band_lower   <= lbhm_pkg::LOWER_RST;
      band_upper   <= lbhm_pkg::UPPER_RST;
      empty_limit  <= lbhm_pkg::EMPTY_RST;
      hold_seconds <= lbhm_pkg::HOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lbhm_pkg::CFG_SCALE_GAIN:   scale_gain   <= cfg_data[lbhm_pkg::GAIN_W-1:0];
        lbhm_pkg::CFG_SCALE_OFFSET: scale_offset <= $signed(cfg_data[lbhm_pkg::WEIGHT_W-1:0]);
        lbhm_pkg::CFG_BAND_LOWER:   band_lower   <= cfg_data[lbhm_pkg::LIMIT_W-1:0];
        lbhm_pkg::CFG_BAND_UPPER:   band_upper   <= cfg_data[lbhm_pkg::LIMIT_W-1:0];
        lbhm_pkg::CFG_EMPTY_LIMIT:  empty_limit  <= cfg_data[lbhm_pkg::LIMIT_W-1:0];
        lbhm_pkg::CFG_HOLD_SECONDS: hold_seconds <= cfg_data[lbhm_pkg::HOLD_W-1:0];
        default: begin
          // Indexes past the register list are dropped.
        end
      endcase
    end
  end

  // The word in the input register moves on whenever the output register is
  // empty or is being emptied in this cycle. The input register accepts a new
  // word whenever it is empty or its word moves on.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_raw  <= raw_reading;
      in_tick <= second_tick;
    end
  end

  lbhm_scale u_scale (
    .raw_reading  (in_raw),
    .scale_gain   (scale_gain),
    .scale_offset (scale_offset),
    .scaled       (scaled)
  );

  // The first sample after reset becomes the tare if the tray looks empty,
  // and the same sample is already measured against that tare.
  always_comb begin
    tare_next = tare_value;
    if (first_sample && !lbhm_pkg::at_least(scaled, empty_limit)) begin
      tare_next = scaled;
    end
  end

  assign weight = lbhm_pkg::sat_weight(lbhm_pkg::SUM_W'(scaled) -
                                       lbhm_pkg::SUM_W'(tare_next));
  assign band   = lbhm_pkg::at_least(weight, band_lower) &&
                  !lbhm_pkg::at_least(weight, band_upper);
  assign loaded = lbhm_pkg::at_least(weight, empty_limit);

  // Phase transitions and countdown update.
  always_comb begin
    phase_next             = phase_reg;
    countdown_next         = countdown;
    countdown_visible_next = countdown_visible;
    case (phase_reg)
      lbhm_pkg::PH_INIT: begin
        phase_next = lbhm_pkg::PH_IDLE;
      end
      lbhm_pkg::PH_IDLE: begin
        if (loaded) begin
          phase_next = lbhm_pkg::PH_OUT;
        end
      end
      lbhm_pkg::PH_OUT: begin
        if (band) begin
          phase_next             = lbhm_pkg::PH_IN;
          countdown_next         = lbhm_pkg::CNT_W'(hold_seconds);
          countdown_visible_next = 1'b1;
        end else if (!loaded) begin
          phase_next = lbhm_pkg::PH_INIT;
        end
      end
      lbhm_pkg::PH_IN: begin
        if (!band) begin
          phase_next             = lbhm_pkg::PH_OUT;
          countdown_visible_next = 1'b0;
        end else begin
          // The count bottoms out at the most negative 7-bit value.
          if (in_tick && (countdown != {1'b1, {(lbhm_pkg::CNT_W-1){1'b0}}})) begin
            countdown_next = countdown - lbhm_pkg::CNT_W'(1);
          end
          if (countdown_next[lbhm_pkg::CNT_W-1]) begin
            phase_next = lbhm_pkg::PH_DONE;
          end
        end
      end
      lbhm_pkg::PH_DONE: begin
        if (!loaded) begin
          phase_next             = lbhm_pkg::PH_INIT;
          countdown_visible_next = 1'b0;
        end
      end
      default: begin
        phase_next = lbhm_pkg::PH_INIT;
      end
    endcase
  end

  // Result fields: the seconds are shown only while holding in range.
  always_comb begin
    seconds_next = '0;
    if ((phase_next == lbhm_pkg::PH_IN) && !countdown_next[lbhm_pkg::CNT_W-1]) begin
      seconds_next = countdown_next[lbhm_pkg::HOLD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg         <= lbhm_pkg::PH_INIT;
      tare_value        <= '0;
      first_sample      <= 1'b1;
      countdown         <= '0;
      countdown_visible <= 1'b0;
    end else if (advance) begin
      phase_reg         <= phase_next;
      tare_value        <= tare_next;
      first_sample      <= 1'b0;
      countdown         <= countdown_next;
      countdown_visible <= countdown_visible_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      net_weight      <= weight;
      phase           <= phase_next;
      in_band         <= band;
      seconds_left    <= seconds_next;
      countdown_shown <= countdown_visible_next;
    end
  end

endmodule

### rtl/lbhm_scale.sv
// ---------------------------------------------------------------------------
// lbhm_scale
// Converts a raw converter sample to a saturated weight in 1/256 kg.
// ---------------------------------------------------------------------------
module lbhm_scale (
  input  logic signed [lbhm_pkg::RAW_W-1:0]    raw_reading,
  input  logic [lbhm_pkg::GAIN_W-1:0]          scale_gain,
  input  logic signed [lbhm_pkg::WEIGHT_W-1:0] scale_offset,
  output logic signed [lbhm_pkg::WEIGHT_W-1:0] scaled
);

  localparam int PROD_W = lbhm_pkg::RAW_W + lbhm_pkg::GAIN_W + 1;
  localparam int Q_W    = PROD_W - 24;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rounded;
  logic signed [Q_W-1:0]    q;
  logic signed [lbhm_pkg::SUM_W-1:0] sum;

  // Product is in 2^-24 of the weight unit; add one half and floor.
  assign prod    = PROD_W'(raw_reading) * $signed({1'b0, scale_gain});
  assign rounded = prod + PROD_W'(64'sd8388608);
  assign q       = rounded[PROD_W-1:24];
  assign sum     = lbhm_pkg::SUM_W'(q) + lbhm_pkg::SUM_W'(scale_offset);
  assign scaled  = lbhm_pkg::sat_weight(sum);

endmodule

### rtl/lbhm_checker.sv
// ---------------------------------------------------------------------------
// lbhm_port_checks
// Port-level checks of the monitor, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "load_band_hold_monitor_core_assert.svh"

module lbhm_port_checks (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [lbhm_pkg::WEIGHT_W-1:0] net_weight,
  input logic [2:0]                           phase,
  input logic                                 in_band,
  input logic [lbhm_pkg::HOLD_W-1:0]          seconds_left,
  input logic                                 countdown_shown
);

  // A result held by the receiver keeps its contents.
  `LBHM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(net_weight) && $stable(phase) && $stable(seconds_left))

  // Holding in range is only possible in the band and with the countdown shown.
  `LBHM_ASSERT_SAME(a_in_range_band, clk, rst,
    out_valid && (phase == lbhm_pkg::PH_IN), in_band && countdown_shown)

  // Seconds appear only while holding in range.
  `LBHM_ASSERT_SAME(a_seconds_phase, clk, rst,
    out_valid && (seconds_left != '0), phase == lbhm_pkg::PH_IN)

  // The countdown display belongs to the in range and completed phases.
  `LBHM_ASSERT_SAME(a_shown_phase, clk, rst, out_valid && countdown_shown,
    (phase == lbhm_pkg::PH_IN) || (phase == lbhm_pkg::PH_DONE))

endmodule

bind load_band_hold_monitor_core lbhm_port_checks u_lbhm_port_checks (.*);
